/* sv/mfd_pkg.sv */
// shared types and constants for the market feed packet deframer
package mfd_pkg;

  // result queue between parser and record emitter
  localparam int QUEUE_DEPTH = 4;

  // header layout (byte counts after the byte is taken)
  localparam logic [4:0] SES_TOP_BYTES = 5'd2;
  localparam logic [4:0] SES_BOT_BYTES = 5'd10;
  localparam logic [4:0] SEQ_BYTES     = 5'd18;
  localparam logic [4:0] HDR_BYTES     = 5'd20;

  // record kinds
  localparam logic [1:0] REC_HEADER    = 2'd0;
  localparam logic [1:0] REC_MSG_START = 2'd1;
  localparam logic [1:0] REC_PAYLOAD   = 2'd2;
  localparam logic [1:0] REC_PKT_END   = 2'd3;

  // packet kinds
  localparam logic [1:0] PK_DATA        = 2'd0;
  localparam logic [1:0] PK_HEARTBEAT   = 2'd1;
  localparam logic [1:0] PK_END_SESSION = 2'd2;
  localparam logic [1:0] PK_REQUEST     = 2'd3;

  // special message counts
  localparam logic [15:0] CNT_HEARTBEAT   = 16'h0000;
  localparam logic [15:0] CNT_END_SESSION = 16'hFFFF;

  // end record status
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_ERROR = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_TRAILING,
    PH_DRAIN
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       mode;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [15:0] session_high;
    logic [63:0] session_low;
    logic [63:0] seq_num;
    logic [15:0] msg_total;
    logic [1:0]  packet_kind;
    logic [15:0] msg_len;
    logic [7:0]  payload_byte;
    logic        last_in_message;
    logic        status;
    logic        last_record;
  } out_item_t;

  // one request's worth of records: a first record and an optional end record
  typedef struct packed {
    out_item_t first;
    logic      has_end;
    logic      end_status;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

/* sv/mfd_front.sv */
// byte parser: tracks packet phase and classifies each request into queue entries
module mfd_front import mfd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  q_stat_t  q_stat,
  output logic     push,
  output q_entry_t push_entry
);

  phase_t      phase_r, phase_nxt;
  logic [4:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic        is_req_r, is_req_nxt;
  logic [15:0] ses_top_r, ses_top_nxt;
  logic [63:0] ses_bot_r, ses_bot_nxt;
  logic [63:0] first_seq_r, first_seq_nxt;
  logic [15:0] msg_cnt_r, msg_cnt_nxt;
  logic [15:0] msg_idx_r, msg_idx_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] remain_r, remain_nxt;

  logic        acc;
  logic [7:0]  b;
  logic        last;
  logic [64:0] seq_sum;
  logic [15:0] idx_inc;
  logic [15:0] len_full;
  logic [15:0] remain_dec;
  logic [1:0]  pk;
  logic        msg_done;
  logic        has_first;
  q_entry_t    ent;

  assign in_stall = q_stat.full;
  assign acc      = in_valid && !q_stat.full;
  assign b        = in_data.data_byte;
  assign last     = in_data.last_byte;

  // sequence of the current message, carry flags a wrap past 2^64-1
  assign seq_sum    = {1'b0, first_seq_r} + {49'd0, msg_idx_r};
  assign idx_inc    = msg_idx_r + 16'd1;
  assign len_full   = {len_hi_r, b};
  assign remain_dec = remain_r - 16'd1;

  always_comb begin
    phase_nxt     = phase_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    is_req_nxt    = is_req_r;
    ses_top_nxt   = ses_top_r;
    ses_bot_nxt   = ses_bot_r;
    first_seq_nxt = first_seq_r;
    msg_cnt_nxt   = msg_cnt_r;
    msg_idx_nxt   = msg_idx_r;
    len_hi_nxt    = len_hi_r;
    remain_nxt    = remain_r;
    ent           = '0;
    has_first     = 1'b0;
    msg_done      = 1'b0;
    pk            = PK_DATA;

    if (acc) begin
      case (phase_r)
        PH_IDLE, PH_HEADER: begin
          // new packet starts from a clean header
          if (phase_r == PH_IDLE) begin
            is_req_nxt    = in_data.mode;
            hdr_cnt_nxt   = '0;
            ses_top_nxt   = '0;
            ses_bot_nxt   = '0;
            first_seq_nxt = '0;
            msg_cnt_nxt   = '0;
            msg_idx_nxt   = '0;
          end
          if (hdr_cnt_nxt < SES_TOP_BYTES) begin
            ses_top_nxt = {ses_top_nxt[7:0], b};
          end else if (hdr_cnt_nxt < SES_BOT_BYTES) begin
            ses_bot_nxt = {ses_bot_nxt[55:0], b};
          end else if (hdr_cnt_nxt < SEQ_BYTES) begin
            first_seq_nxt = {first_seq_nxt[55:0], b};
          end else begin
            msg_cnt_nxt = {msg_cnt_nxt[7:0], b};
          end
          hdr_cnt_nxt = hdr_cnt_nxt + 5'd1;

          if (hdr_cnt_nxt != HDR_BYTES) begin
            if (last) begin
              has_first              = 1'b1;
              ent.first.record_kind  = REC_PKT_END;
              ent.first.status       = ST_ERROR;
              phase_nxt              = PH_IDLE;
            end else begin
              phase_nxt = PH_HEADER;
            end
          end else begin
            if (is_req_nxt) begin
              pk = PK_REQUEST;
            end else if (msg_cnt_nxt == CNT_HEARTBEAT) begin
              pk = PK_HEARTBEAT;
            end else if (msg_cnt_nxt == CNT_END_SESSION) begin
              pk = PK_END_SESSION;
            end else begin
              pk = PK_DATA;
            end
            has_first              = 1'b1;
            ent.first.record_kind  = REC_HEADER;
            ent.first.session_high = ses_top_nxt;
            ent.first.session_low  = ses_bot_nxt;
            ent.first.seq_num      = first_seq_nxt;
            ent.first.msg_total    = msg_cnt_nxt;
            ent.first.packet_kind  = pk;
            if (pk != PK_DATA) begin
              if (last) begin
                ent.has_end    = 1'b1;
                ent.end_status = ST_OK;
                phase_nxt      = PH_IDLE;
              end else begin
                phase_nxt = PH_TRAILING;
              end
            end else begin
              msg_idx_nxt = '0;
              if (last) begin
                ent.has_end    = 1'b1;
                ent.end_status = ST_ERROR;
                phase_nxt      = PH_IDLE;
              end else begin
                phase_nxt = PH_LEN_HI;
              end
            end
          end
        end

        PH_LEN_HI: begin
          if (seq_sum[64]) begin
            has_first             = 1'b1;
            ent.first.record_kind = REC_PKT_END;
            ent.first.status      = ST_ERROR;
            phase_nxt             = last ? PH_IDLE : PH_DRAIN;
          end else begin
            len_hi_nxt = b;
            if (last) begin
              has_first             = 1'b1;
              ent.first.record_kind = REC_PKT_END;
              ent.first.status      = ST_ERROR;
              phase_nxt             = PH_IDLE;
            end else begin
              phase_nxt = PH_LEN_LO;
            end
          end
        end

        PH_LEN_LO: begin
          has_first             = 1'b1;
          ent.first.record_kind = REC_MSG_START;
          ent.first.seq_num     = seq_sum[63:0];
          ent.first.msg_len     = len_full;
          if (len_full == 16'd0) begin
            msg_done = 1'b1;
          end else begin
            remain_nxt = len_full;
            if (last) begin
              ent.has_end    = 1'b1;
              ent.end_status = ST_ERROR;
              phase_nxt      = PH_IDLE;
            end else begin
              phase_nxt = PH_PAYLOAD;
            end
          end
        end

        PH_PAYLOAD: begin
          has_first              = 1'b1;
          ent.first.record_kind  = REC_PAYLOAD;
          ent.first.payload_byte = b;
          remain_nxt             = remain_dec;
          if (remain_dec == 16'd0) begin
            ent.first.last_in_message = 1'b1;
            msg_done                  = 1'b1;
          end else if (last) begin
            ent.has_end    = 1'b1;
            ent.end_status = ST_ERROR;
            phase_nxt      = PH_IDLE;
          end
        end

        PH_TRAILING: begin
          has_first             = 1'b1;
          ent.first.record_kind = REC_PKT_END;
          ent.first.status      = ST_ERROR;
          phase_nxt             = last ? PH_IDLE : PH_DRAIN;
        end

        PH_DRAIN: begin
          if (last) begin
            phase_nxt = PH_IDLE;
          end
        end

        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase

      // end of a message: next length, trailing check or packet end
      if (msg_done) begin
        msg_idx_nxt = idx_inc;
        if (idx_inc == msg_cnt_r) begin
          if (last) begin
            ent.has_end    = 1'b1;
            ent.end_status = ST_OK;
            phase_nxt      = PH_IDLE;
          end else begin
            phase_nxt = PH_TRAILING;
          end
        end else if (last) begin
          ent.has_end    = 1'b1;
          ent.end_status = ST_ERROR;
          phase_nxt      = PH_IDLE;
        end else begin
          phase_nxt = PH_LEN_HI;
        end
      end
    end
  end

  assign push       = has_first;
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      hdr_cnt_r   <= '0;
      is_req_r    <= 1'b0;
      msg_cnt_r   <= '0;
      msg_idx_r   <= '0;
      remain_r    <= '0;
      ses_top_r   <= '0;
      ses_bot_r   <= '0;
      first_seq_r <= '0;
      len_hi_r    <= '0;
    end else begin
      phase_r     <= phase_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      is_req_r    <= is_req_nxt;
      msg_cnt_r   <= msg_cnt_nxt;
      msg_idx_r   <= msg_idx_nxt;
      remain_r    <= remain_nxt;
      ses_top_r   <= ses_top_nxt;
      ses_bot_r   <= ses_bot_nxt;
      first_seq_r <= first_seq_nxt;
      len_hi_r    <= len_hi_nxt;
    end
  end

endmodule

/* sv/mfd_queue.sv */
// short register queue of parsed entries between parser and emitter
module mfd_queue import mfd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output q_entry_t pop_entry,
  output q_stat_t  q_stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign pop_entry    = mem_r[rd_ptr_r];
  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == CW'(DEPTH));

endmodule

/* sv/mfd_back.sv */
// record emitter: unpacks queue entries into one record per cycle on the output register while out_stall is low
module mfd_back import mfd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_stat_t   q_stat,
  input  q_entry_t  pop_entry,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      pend_r, pend_nxt;
  logic      pend_err_r, pend_err_nxt;
  logic      load;

  assign load = !out_valid_r || !out_stall;
  assign pop  = load && !pend_r && !q_stat.empty;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    pend_nxt      = pend_r;
    pend_err_nxt  = pend_err_r;
    if (load) begin
      if (pend_r) begin
        // trailing end record of the same request
        out_valid_nxt            = 1'b1;
        out_data_nxt             = '0;
        out_data_nxt.record_kind = REC_PKT_END;
        out_data_nxt.status      = pend_err_r;
        out_data_nxt.last_record = 1'b1;
        pend_nxt                 = 1'b0;
      end else if (!q_stat.empty) begin
        out_valid_nxt            = 1'b1;
        out_data_nxt             = pop_entry.first;
        out_data_nxt.last_record = !pop_entry.has_end;
        pend_nxt                 = pop_entry.has_end;
        pend_err_nxt             = pop_entry.end_status;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    pend_err_r <= pend_err_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/market_feed_packet_deframer.sv */
// top level of the market feed packet deframer
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   in_     | input     | in_valid / in_stall  | in_item_t: one packet byte
//   out_    | output    | out_valid / out_stall| out_item_t: one parsed record
//
// one byte request is taken per cycle while the entry queue is not full; the parser never waits on its own work
// each byte gives zero, one or two records; the output register sends one a cycle
//   while out_stall is low, so a byte that gives two holds off the next pop until both are sent
// first record of a byte is written into the entry queue at the accepting edge
//   and then loaded into the output register once the emitter can take it
// in_stall rises only when the entry queue (Q_DEPTH entries) is full
// reset is synchronous and active low; no clearing pass is needed after it
module market_feed_packet_deframer import mfd_pkg::*; #(
  parameter int Q_DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // parser to queue
  logic     push;
  q_entry_t push_entry;

  // queue to emitter
  logic     pop;
  q_entry_t pop_entry;
  q_stat_t  q_stat;

  // front: header assembly, message framing, error detection
  mfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // decoupling queue: lets the parser run on while the output is stalled
  mfd_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_stat     (q_stat)
  );

  // back: expands each entry into its records, sets last_record
  mfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_entry (pop_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* sv/mfd_checker.sv */
// port-level assertions for the market feed packet deframer, bound to the top level
module mfd_checker import mfd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled input request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input request changed");

  // a stalled record holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output record changed");

  // end of message flag only on payload records
  a_last_msg_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_in_message |-> out_data.record_kind == REC_PAYLOAD)
    else $error("last_in_message on a non-payload record");

  // packet end is always the final record of its byte
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.record_kind == REC_PKT_END |-> out_data.last_record)
    else $error("packet end record without last_record");

  // reset empties the output
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind market_feed_packet_deframer mfd_checker u_mfd_checker (.*);

/* tb/tb_top.sv */
// self-checking testbench for the market feed packet deframer
`timescale 1ns / 1ps

module tb_top;
  import mfd_pkg::*;

  // how hard each side idles in the current stretch of the run
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  idle_mode_t idle_mode = IDLE_NONE;

  // bytes waiting to be offered, and records the deframer still owes us
  in_item_t  byte_backlog[$];
  out_item_t expected_records[$];
  out_item_t step_recs[$];

  int bytes_built = 0;
  int packets_built = 0;
  int bytes_taken = 0;
  int records_checked = 0;
  int mismatches = 0;

  // shadow of the parser state
  phase_t      ph = PH_IDLE;
  logic [4:0]  hdr_cnt = '0;
  logic        is_req = 1'b0;
  logic [15:0] ses_top = '0;
  logic [63:0] ses_bot = '0;
  logic [63:0] first_seq = '0;
  logic [15:0] msg_count = '0;
  logic [15:0] msg_idx = '0;
  logic [15:0] len_acc = '0;
  logic [15:0] pay_left = '0;

  market_feed_packet_deframer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // deframing predictor: one accepted byte in, zero to two records out
  // ---------------------------------------------------------------------------

  function automatic out_item_t blank_record(logic [1:0] kind);
    out_item_t r;
    r = '0;
    r.record_kind = kind;
    return r;
  endfunction

  function automatic void emit_end(logic st);
    out_item_t r;
    r = blank_record(REC_PKT_END);
    r.status = st;
    step_recs.insert(step_recs.size(), r);
  endfunction

  // error end record, then throw away the rest of the packet
  function automatic void abort_packet(logic last);
    emit_end(ST_ERROR);
    ph = last ? PH_IDLE : PH_DRAIN;
  endfunction

  function automatic void close_message(logic last);
    msg_idx = msg_idx + 16'd1;
    if (msg_idx == msg_count) begin
      if (last) begin
        emit_end(ST_OK);
        ph = PH_IDLE;
      end else begin
        ph = PH_TRAILING;
      end
    end else if (last) begin
      // packet ended while more messages were due
      abort_packet(1'b1);
    end else begin
      ph = PH_LEN_HI;
    end
  endfunction

  function automatic void take_header_byte(logic [7:0] b, logic last);
    out_item_t r;
    logic [1:0] pk;
    // header bytes shift into session, sequence and count, all big-endian
    if (hdr_cnt < SES_TOP_BYTES) ses_top = {ses_top[7:0], b};
    else if (hdr_cnt < SES_BOT_BYTES) ses_bot = {ses_bot[55:0], b};
    else if (hdr_cnt < SEQ_BYTES) first_seq = {first_seq[55:0], b};
    else msg_count = {msg_count[7:0], b};
    hdr_cnt = hdr_cnt + 5'd1;

    if (hdr_cnt != HDR_BYTES) begin
      // short header when the packet ends here
      if (last) abort_packet(1'b1);
      else ph = PH_HEADER;
    end else begin
      if (is_req) pk = PK_REQUEST;
      else if (msg_count == CNT_HEARTBEAT) pk = PK_HEARTBEAT;
      else if (msg_count == CNT_END_SESSION) pk = PK_END_SESSION;
      else pk = PK_DATA;
      r = blank_record(REC_HEADER);
      r.session_high = ses_top;
      r.session_low  = ses_bot;
      r.seq_num      = first_seq;
      r.msg_total    = msg_count;
      r.packet_kind  = pk;
      step_recs.insert(step_recs.size(), r);
      if (pk != PK_DATA) begin
        // header-only packet kinds: anything after the header is trailing
        if (last) begin
          emit_end(ST_OK);
          ph = PH_IDLE;
        end else begin
          ph = PH_TRAILING;
        end
      end else begin
        msg_idx = '0;
        if (last) abort_packet(1'b1);
        else ph = PH_LEN_HI;
      end
    end
  endfunction

  function automatic void deframe_byte(in_item_t it);
    out_item_t r;
    step_recs.delete();
    case (ph)
      PH_HEADER: take_header_byte(it.data_byte, it.last_byte);
      PH_LEN_HI: begin
        // sequence of this message must not run past 2^64-1
        if (first_seq > (64'hFFFF_FFFF_FFFF_FFFF - {48'd0, msg_idx})) begin
          abort_packet(it.last_byte);
        end else begin
          len_acc = {8'd0, it.data_byte};
          if (it.last_byte) abort_packet(1'b1);
          else ph = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        len_acc = {len_acc[7:0], it.data_byte};
        r = blank_record(REC_MSG_START);
        r.seq_num = first_seq + {48'd0, msg_idx};
        r.msg_len = len_acc;
        step_recs.insert(step_recs.size(), r);
        if (len_acc == 16'd0) begin
          // zero-length message: the start record is all there is
          close_message(it.last_byte);
        end else begin
          pay_left = len_acc;
          if (it.last_byte) abort_packet(1'b1);
          else ph = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        r = blank_record(REC_PAYLOAD);
        r.payload_byte = it.data_byte;
        pay_left = pay_left - 16'd1;
        if (pay_left == 16'd0) begin
          r.last_in_message = 1'b1;
          step_recs.insert(step_recs.size(), r);
          close_message(it.last_byte);
        end else begin
          step_recs.insert(step_recs.size(), r);
          if (it.last_byte) abort_packet(1'b1);
        end
      end
      PH_TRAILING: abort_packet(it.last_byte);
      PH_DRAIN: begin
        if (it.last_byte) ph = PH_IDLE;
      end
      default: begin
        // first byte of a packet: mode is sampled here and everything restarts
        is_req    = it.mode;
        hdr_cnt   = '0;
        ses_top   = '0;
        ses_bot   = '0;
        first_seq = '0;
        msg_count = '0;
        msg_idx   = '0;
        len_acc   = '0;
        pay_left  = '0;
        take_header_byte(it.data_byte, it.last_byte);
      end
    endcase
    if (step_recs.size() > 0) begin
      step_recs[step_recs.size() - 1].last_record = 1'b1;
    end
    foreach (step_recs[i]) expected_records.insert(expected_records.size(), step_recs[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // packet builders
  // ---------------------------------------------------------------------------

  function automatic logic [79:0] rand_session();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return raw[79:0];
    endcase
  endfunction

  function automatic logic [63:0] rand_seq();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // header, then nmsg messages regardless of the count field, then extra junk;
  // cut >= 0 truncates the packet so that byte cut carries the end mark
  task automatic add_packet(input logic req, input logic [79:0] ses, input logic [63:0] seq,
                            input logic [15:0] count, input int nmsg, input int maxlen,
                            input logic big_first, input int extra, input int cut);
    in_item_t pkt[$];
    in_item_t it;
    logic [159:0] hdr;
    logic [15:0] len;
    int k, m, j, npay;
    hdr = {ses, seq, count};
    for (k = 0; k < 20; k++) begin
      it.data_byte = hdr[159 - 8 * k -: 8];
      it.mode      = (k == 0) ? req : 1'($urandom);
      it.last_byte = 1'b0;
      pkt.insert(pkt.size(), it);
    end
    for (m = 0; m < nmsg; m++) begin
      if (big_first && m == 0) len = 16'($urandom_range(7, 65535));
      else len = 16'($urandom_range(0, maxlen));
      it.data_byte = len[15:8];
      it.mode = 1'($urandom);
      pkt.insert(pkt.size(), it);
      it.data_byte = len[7:0];
      it.mode = 1'($urandom);
      pkt.insert(pkt.size(), it);
      // long messages are only started, never sent whole
      npay = (len > 16'd6) ? 6 : int'(len);
      for (j = 0; j < npay; j++) begin
        it.data_byte = 8'($urandom);
        it.mode = 1'($urandom);
        pkt.insert(pkt.size(), it);
      end
    end
    for (j = 0; j < extra; j++) begin
      it.data_byte = 8'($urandom);
      it.mode = 1'($urandom);
      pkt.insert(pkt.size(), it);
    end
    if (cut >= 0) begin
      while (pkt.size() > cut + 1) void'(pkt.pop_back());
    end
    pkt[pkt.size() - 1].last_byte = 1'b1;
    foreach (pkt[i]) byte_backlog.insert(byte_backlog.size(), pkt[i]);
    bytes_built += pkt.size();
    packets_built++;
  endtask

  task automatic add_noise(input int n);
    in_item_t it;
    int j;
    for (j = 0; j < n; j++) begin
      it.data_byte = 8'($urandom);
      it.mode      = 1'($urandom);
      it.last_byte = (j == n - 1);
      byte_backlog.insert(byte_backlog.size(), it);
    end
    bytes_built += n;
    packets_built++;
  endtask

  task automatic add_random_packet();
    int pick, n;
    pick = $urandom_range(0, 99);
    n = $urandom_range(1, 3);
    if (pick < 45) begin
      // well-formed data packet
      add_packet(1'b0, rand_session(), rand_seq(), 16'(n), n, 6, 1'b0, 0, -1);
    end else if (pick < 55) begin
      add_packet(1'b0, rand_session(), rand_seq(),
                 $urandom_range(0, 1) ? CNT_END_SESSION : CNT_HEARTBEAT, 0, 0, 1'b0,
                 ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0, -1);
    end else if (pick < 65) begin
      add_packet(1'b1, rand_session(), rand_seq(), 16'($urandom), 0, 0, 1'b0,
                 ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0, -1);
    end else if (pick < 77) begin
      // truncated somewhere in the packet
      add_packet(1'b0, rand_session(), rand_seq(), 16'(n), n, 6, 1'b0, 0,
                 $urandom_range(0, 20 + 8 * n));
    end else if (pick < 85) begin
      // count field disagrees with the messages sent
      add_packet(1'b0, rand_session(), rand_seq(),
                 16'($urandom_range(0, 1) ? n + 1 : n - 1), n, 4, 1'b0, 0, -1);
    end else if (pick < 92) begin
      // sequence numbers run off the top
      add_packet(1'b0, rand_session(), 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 2)),
                 16'd4, 4, 2, 1'b0, 0, -1);
    end else if (pick < 96) begin
      add_packet(1'b0, rand_session(), rand_seq(), 16'd1, 1, 6, 1'b1, 0, -1);
    end else begin
      add_noise($urandom_range(1, 25));
    end
  endtask

  function automatic int gap_pct(idle_mode_t md);
    case (md)
      IDLE_SEND: return 78;
      IDLE_BOTH: return 36;
      default:   return 0;
    endcase
  endfunction

  function automatic int stall_pct(idle_mode_t md);
    case (md)
      IDLE_RECV: return 78;
      IDLE_BOTH: return 36;
      default:   return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers backlog bytes, predicts each request as it is accepted
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_data);
        bytes_taken++;
      end
      // a stalled request holds its payload; otherwise pick the next one or idle
      if (!in_valid || !in_stall) begin
        if (byte_backlog.size() > 0 && $urandom_range(0, 99) >= gap_pct(idle_mode)) begin
          in_valid <= 1'b1;
          in_data  <= byte_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each accepted record against the oldest prediction
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %0d: %s", mismatches, msg);
  endtask

  task automatic check_record(input out_item_t exp, input out_item_t got);
    string bad;
    bad = "";
    if (got.record_kind !== exp.record_kind) bad = {bad, " record_kind"};
    if (got.session_high !== exp.session_high) bad = {bad, " session_high"};
    if (got.session_low !== exp.session_low) bad = {bad, " session_low"};
    if (got.seq_num !== exp.seq_num) bad = {bad, " seq_num"};
    if (got.msg_total !== exp.msg_total) bad = {bad, " msg_total"};
    if (got.packet_kind !== exp.packet_kind) bad = {bad, " packet_kind"};
    if (got.msg_len !== exp.msg_len) bad = {bad, " msg_len"};
    if (got.payload_byte !== exp.payload_byte) bad = {bad, " payload_byte"};
    if (got.last_in_message !== exp.last_in_message) bad = {bad, " last_in_message"};
    if (got.status !== exp.status) bad = {bad, " status"};
    if (got.last_record !== exp.last_record) bad = {bad, " last_record"};
    if (bad != "")
      note_mismatch($sformatf("record %0d differs in%s: expected %h got %h",
                              records_checked, bad, exp, got));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_records.size() == 0)
          note_mismatch($sformatf("unexpected record %h", out_data));
        else
          check_record(expected_records.pop_front(), out_data);
        records_checked++;
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct(idle_mode));
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    int p, start;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (p = 0; p < 4; p++) begin
      @(negedge clk);
      case (p)
        0: idle_mode = IDLE_NONE;
        1: idle_mode = IDLE_SEND;
        2: idle_mode = IDLE_RECV;
        default: idle_mode = IDLE_BOTH;
      endcase
      if (p == 0) begin
        // directed packets
        // header cut after one byte
        add_packet(1'b0, '0, '0, 16'd1, 1, 2, 1'b0, 0, 0);
        // heartbeat with all-ones session and sequence
        add_packet(1'b0, '1, '1, CNT_HEARTBEAT, 0, 0, 1'b0, 0, -1);
        add_packet(1'b0, rand_session(), rand_seq(), CNT_END_SESSION, 0, 0, 1'b0, 0, -1);
        // end of session with bytes after it, rest of packet dropped
        add_packet(1'b0, rand_session(), rand_seq(), CNT_END_SESSION, 0, 0, 1'b0, 2, -1);
        add_packet(1'b1, '0, '0, 16'hFFFF, 0, 0, 1'b0, 0, -1);
        // request followed by a stray byte
        add_packet(1'b1, rand_session(), rand_seq(), 16'h0000, 0, 0, 1'b0, 1, -1);
        // data header that is the whole packet
        add_packet(1'b0, rand_session(), rand_seq(), 16'd5, 0, 0, 1'b0, 0, -1);
        // zero-length messages, the last one ending the packet
        add_packet(1'b0, rand_session(), rand_seq(), 16'd2, 2, 0, 1'b0, 0, -1);
        add_packet(1'b0, rand_session(), rand_seq(), 16'd3, 3, 5, 1'b0, 0, -1);
        // packet ends inside a length field
        add_packet(1'b0, rand_session(), rand_seq(), 16'd1, 1, 4, 1'b0, 0, 20);
        // long message cut inside its payload
        add_packet(1'b0, rand_session(), rand_seq(), 16'd1, 1, 4, 1'b1, 0, 24);
        // trailing bytes after the final message
        add_packet(1'b0, rand_session(), rand_seq(), 16'd1, 1, 3, 1'b0, 3, -1);
        // more messages promised than sent
        add_packet(1'b0, rand_session(), rand_seq(), 16'd3, 1, 3, 1'b0, 0, -1);
        // sequence wrap on the second message
        add_packet(1'b0, rand_session(), '1, 16'd3, 3, 1, 1'b0, 0, -1);
      end
      start = bytes_built;
      while (bytes_built - start < 125) add_random_packet();
      while (byte_backlog.size() != 0 || in_valid) @(negedge clk);
    end

    idle_mode = IDLE_NONE;
    while (expected_records.size() != 0) @(negedge clk);
    // then keep the clock running so that any stray record still shows up
    repeat (8) @(negedge clk);

    $display("ran %0d packets, %0d bytes accepted, %0d records checked",
             packets_built, bytes_taken, records_checked);
    $display("idle phases: none, sender gaps, receiver stalls, both; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d records still expected", expected_records.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
